@@ sv/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the strided cumulative sum core
// Widths, register indexes, stream packing and the geometry bundle.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int STRIDE_DEPTH = 4096;
	localparam int SAMPLE_BITS  = 32;
	localparam int SUM_BITS     = 48;
	localparam int SIZE_BITS    = 16;
	localparam int NUM_DIMS     = 4;

	localparam int ADDR_W = (STRIDE_DEPTH > 1) ? $clog2(STRIDE_DEPTH) : 1;
	// holds STRIDE_DEPTH + 1, the clamp mark for a stride that is too long
	localparam int KW     = $clog2(STRIDE_DEPTH + 2);

	localparam logic [1:0] LAST_DIM = 2'd3;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_REGS   = 7;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_ROWS    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_COLS    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_SLICES  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_HYPER   = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COL_MAJOR    = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_DIM      = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE = 8'd6;

	// geometry pipeline depth after a register write
	localparam int SETTLE_CYCLES = 3;
	localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

	localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * SUM_BITS + 7) / 8) * 8;
	localparam int USER_W      = 2;
	localparam int USER_SAT    = 0;
	localparam int USER_ERR    = 1;

	typedef struct packed {
		logic [KW-1:0]        stride;
		logic [SIZE_BITS-1:0] len;
		logic                 too_long;
		logic                 cplx;
		logic                 settled;
		logic                 restart;
	} geom_t;

endpackage

@@ sv/scs_geom.sv @@
// ----------------------------------------------------------------------------
// scs_geom: configuration registers and stride geometry
// Holds the tensor registers and derives stride, run length and overflow
// flag through a short multiply pipeline.
// ----------------------------------------------------------------------------
module scs_geom (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scs_pkg::CFG_DATA_W-1:0] cfg_data,
	output scs_pkg::geom_t                 geom
);

	logic [scs_pkg::SIZE_BITS-1:0] size_q [scs_pkg::NUM_DIMS];
	logic                          col_major_q;
	logic [1:0]                    sum_dim_q;
	logic                          cplx_q;
	logic [scs_pkg::SETTLE_W-1:0]  settle_q;
	logic                          hit;

	logic [scs_pkg::KW-1:0]        fac [scs_pkg::NUM_DIMS];
	logic [2*scs_pkg::KW-1:0]      p01_s1, p23_s1, prod_s2;
	logic [scs_pkg::SIZE_BITS-1:0] len_s1;
	logic [scs_pkg::KW-1:0]        stride_q;
	logic                          too_long_q;

	function automatic logic [scs_pkg::SIZE_BITS-1:0] eff_size(
		input logic [scs_pkg::SIZE_BITS-1:0] s);
		eff_size = (s == '0) ? scs_pkg::SIZE_BITS'(1) : s;
	endfunction

	function automatic logic [scs_pkg::KW-1:0] clamp_size(
		input logic [scs_pkg::SIZE_BITS-1:0] s);
		logic [31:0] e;
		e = 32'(eff_size(s));
		clamp_size = (e > 32'(scs_pkg::STRIDE_DEPTH)) ?
			scs_pkg::KW'(scs_pkg::STRIDE_DEPTH + 1) : scs_pkg::KW'(e);
	endfunction

	function automatic logic [scs_pkg::KW-1:0] clamp_prod(
		input logic [2*scs_pkg::KW-1:0] p);
		clamp_prod = (p > (2*scs_pkg::KW)'(scs_pkg::STRIDE_DEPTH)) ?
			scs_pkg::KW'(scs_pkg::STRIDE_DEPTH + 1) : p[scs_pkg::KW-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign hit = cfg_valid && (cfg_index < scs_pkg::CFG_IDX_W'(scs_pkg::NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scs_pkg::NUM_DIMS; i++) begin
				size_q[i] <= scs_pkg::SIZE_BITS'(1);
			end
			col_major_q <= 1'b1;
			sum_dim_q   <= 2'd0;
			cplx_q      <= 1'b0;
			settle_q    <= scs_pkg::SETTLE_W'(scs_pkg::SETTLE_CYCLES);
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					scs_pkg::REG_SIZE_ROWS:    size_q[0]   <= cfg_data;
					scs_pkg::REG_SIZE_COLS:    size_q[1]   <= cfg_data;
					scs_pkg::REG_SIZE_SLICES:  size_q[2]   <= cfg_data;
					scs_pkg::REG_SIZE_HYPER:   size_q[3]   <= cfg_data;
					scs_pkg::REG_COL_MAJOR:    col_major_q <= cfg_data[0];
					scs_pkg::REG_SUM_DIM:      sum_dim_q   <= cfg_data[1:0] & scs_pkg::LAST_DIM;
					scs_pkg::REG_COMPLEX_MODE: cplx_q      <= cfg_data[0];
					default: ;
				endcase
			end
			if (hit) begin
				settle_q <= scs_pkg::SETTLE_W'(scs_pkg::SETTLE_CYCLES);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
		end
	end

	// dims that lie between the summed one and the fast end of memory order
	always_comb begin
		for (int i = 0; i < scs_pkg::NUM_DIMS; i++) begin
			if (col_major_q ? (2'(i) < sum_dim_q) : (2'(i) > sum_dim_q)) begin
				fac[i] = clamp_size(size_q[i]);
			end else begin
				fac[i] = scs_pkg::KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		p01_s1     <= fac[0] * fac[1];
		p23_s1     <= fac[2] * fac[3];
		len_s1     <= eff_size(size_q[sum_dim_q]);
		prod_s2    <= clamp_prod(p01_s1) * clamp_prod(p23_s1);
		stride_q   <= clamp_prod(prod_s2);
		too_long_q <= prod_s2 > (2*scs_pkg::KW)'(scs_pkg::STRIDE_DEPTH);
	end

	assign geom.stride   = stride_q;
	assign geom.len      = len_s1;
	assign geom.too_long = too_long_q;
	assign geom.cplx     = cplx_q;
	assign geom.settled  = (settle_q == '0);
	assign geom.restart  = hit;

endmodule

@@ sv/scs_lane.sv @@
// ----------------------------------------------------------------------------
// scs_lane: one summing lane (real or imaginary part)
// Delay store of prior sums with write bypass, and a saturating adder.
// ----------------------------------------------------------------------------
module scs_lane (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [scs_pkg::ADDR_W-1:0]            rd_addr,
	input  logic                                  wr_en,
	input  logic [scs_pkg::ADDR_W-1:0]            wr_addr,
	input  logic signed [scs_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                  first,
	input  logic                                  pass,
	output logic signed [scs_pkg::SUM_BITS-1:0]   sum,
	output logic                                  clip
);

	logic signed [scs_pkg::SUM_BITS-1:0] mem [scs_pkg::STRIDE_DEPTH];
	logic signed [scs_pkg::SUM_BITS-1:0] rd_q;
	logic signed [scs_pkg::SUM_BITS:0]   prior;
	logic signed [scs_pkg::SUM_BITS:0]   wide;

	localparam logic signed [scs_pkg::SUM_BITS-1:0] SUM_MAX =
		{1'b0, {(scs_pkg::SUM_BITS-1){1'b1}}};
	localparam logic signed [scs_pkg::SUM_BITS-1:0] SUM_MIN =
		{1'b1, {(scs_pkg::SUM_BITS-1){1'b0}}};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= sum;
		end
	end

	// read-before-write array, same-cycle write forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= (wr_en && (wr_addr == rd_addr)) ? sum : mem[rd_addr];
		end
	end

	always_comb begin
		prior = (first || pass) ? '0 : (scs_pkg::SUM_BITS+1)'(rd_q);
		wide  = prior + (scs_pkg::SUM_BITS+1)'(sample);
		clip  = wide[scs_pkg::SUM_BITS] != wide[scs_pkg::SUM_BITS-1];
		if (clip) begin
			sum = wide[scs_pkg::SUM_BITS] ? SUM_MIN : SUM_MAX;
		end else begin
			sum = wide[scs_pkg::SUM_BITS-1:0];
		end
	end

endmodule

@@ sv/strided_cumulative_sum_core.sv @@
// ----------------------------------------------------------------------------
// strided_cumulative_sum_core: running sum along one dimension of a tensor
// Streams tensor elements in memory order and emits the saturated running
// sum along the configured dimension, real and imaginary lanes side by side.
// ----------------------------------------------------------------------------
// Takes one element per clock while s_tready is high and gives one result per
// element through the stage-one registers and the output register. The rate
// is set by the delay-store port of each lane: one read and one write per
// cycle, with the fresh sum forwarded when the stride is short. After every
// write to a valid register index s_tready stays low while the stride
// product settles in the geometry multipliers. The delay stores are not
// cleared after reset; each new tensor writes an entry before using it.
module strided_cumulative_sum_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [scs_pkg::IN_TDATA_W-1:0]   s_tdata,   // sample_re, sample_im
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [scs_pkg::OUT_TDATA_W-1:0]  m_tdata,   // sum_re, sum_im
	output logic                             m_tlast,   // vector_end
	output logic [scs_pkg::USER_W-1:0]       m_tuser,   // saturated, stride_error
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [scs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	scs_pkg::geom_t geom;

	logic                                  accept, out_free, move, dim_last, wrap;
	logic [scs_pkg::ADDR_W-1:0]            stride_pos_q;
	logic [scs_pkg::SIZE_BITS-1:0]         dim_pos_q;
	logic [scs_pkg::KW-1:0]                stride_next;

	logic                                  v_s1_q;
	logic signed [scs_pkg::SAMPLE_BITS-1:0] re_s1, im_s1;
	logic [scs_pkg::ADDR_W-1:0]            addr_s1;
	logic                                  first_s1, vend_s1, err_s1;

	logic signed [scs_pkg::SUM_BITS-1:0]   lane_re, lane_im;
	logic                                  clip_re, clip_im;

	logic                                  out_v_q, sat_q, vend_q, err_q;
	logic [scs_pkg::SUM_BITS-1:0]          sum_re_q, sum_im_q;

	scs_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	assign out_free = !out_v_q || m_tready;
	assign move     = v_s1_q && out_free;
	assign s_tready = geom.settled && !cfg_valid && (!v_s1_q || out_free);
	assign accept   = s_tvalid && s_tready;

	assign stride_next = scs_pkg::KW'(stride_pos_q) + 1'b1;
	assign wrap        = stride_next >= geom.stride;
	assign dim_last    = ({1'b0, dim_pos_q} + 1'b1) >= {1'b0, geom.len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_pos_q <= '0;
			dim_pos_q    <= '0;
		end else if (geom.restart) begin
			stride_pos_q <= '0;
			dim_pos_q    <= '0;
		end else if (accept && !geom.too_long) begin
			if (wrap) begin
				stride_pos_q <= '0;
				dim_pos_q    <= dim_last ? '0 : dim_pos_q + 1'b1;
			end else begin
				stride_pos_q <= stride_next[scs_pkg::ADDR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (accept) begin
			v_s1_q <= 1'b1;
		end else if (move) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			re_s1    <= s_tdata[scs_pkg::SAMPLE_BITS-1:0];
			im_s1    <= geom.cplx ? s_tdata[2*scs_pkg::SAMPLE_BITS-1:scs_pkg::SAMPLE_BITS] : '0;
			addr_s1  <= stride_pos_q;
			first_s1 <= (dim_pos_q == '0);
			vend_s1  <= dim_last;
			err_s1   <= geom.too_long;
		end
	end

	scs_lane u_lane_re (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (stride_pos_q),
		.wr_en   (move && !err_s1),
		.wr_addr (addr_s1),
		.sample  (re_s1),
		.first   (first_s1),
		.pass    (err_s1),
		.sum     (lane_re),
		.clip    (clip_re)
	);

	scs_lane u_lane_im (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (stride_pos_q),
		.wr_en   (move && !err_s1),
		.wr_addr (addr_s1),
		.sample  (im_s1),
		.first   (first_s1),
		.pass    (err_s1),
		.sum     (lane_im),
		.clip    (clip_im)
	);

	// merge lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			sum_re_q <= lane_re;
			sum_im_q <= lane_im;
			sat_q    <= !err_s1 && (clip_re || clip_im);
			vend_q   <= !err_s1 && vend_s1;
			err_q    <= err_s1;
		end
	end

	assign m_tvalid          = out_v_q;
	assign m_tdata           = scs_pkg::OUT_TDATA_W'({sum_im_q, sum_re_q});
	assign m_tlast           = vend_q;
	assign m_tuser[scs_pkg::USER_SAT] = sat_q;
	assign m_tuser[scs_pkg::USER_ERR] = err_q;

`ifndef NO_ASSERTIONS
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[scs_pkg::USER_ERR] |-> !m_tuser[scs_pkg::USER_SAT] && !m_tlast)
		else $error("stride error result carries saturation or run end");

	a_stride_range: assert property (@(posedge clk) disable iff (!arst_n)
		geom.settled && !geom.too_long |-> scs_pkg::KW'(stride_pos_q) < geom.stride)
		else $error("stride position beyond stride");

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		geom.settled |-> dim_pos_q < geom.len)
		else $error("dimension position beyond length");
`endif

endmodule

@@ tb/sv/strided_cumulative_sum_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_cumulative_sum_core_tb: self-checking bench for the cumulative sum core
// A directed table covers the sample extremes, zero sizes, over-long strides,
// ignored register indexes and real/complex mode. Random tensor phases follow,
// each under a fresh geometry. A behavioral model of the strided running sum
// predicts each result that the table does not list, and each output transfer
// is checked field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module strided_cumulative_sum_core_tb;
	import scs_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_IDLE     = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_PHASES   = 11;

	localparam logic [CFG_IDX_W-1:0] REG_PAST_END = CFG_IDX_W'(NUM_REGS);
	localparam logic [CFG_IDX_W-1:0] REG_TOP      = '1;

	localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [SUM_BITS-1:0] W_MAX = {{(SUM_BITS-SAMPLE_BITS){1'b0}}, S_MAX};
	localparam logic [SUM_BITS-1:0] W_MIN = {{(SUM_BITS-SAMPLE_BITS){1'b1}}, S_MIN};

	localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS-1)) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;

	typedef struct packed {
		logic [SUM_BITS-1:0] re;
		logic [SUM_BITS-1:0] im;
		logic                sat;
		logic                last;
		logic                err;
	} csum_t;

	typedef struct packed {
		logic                   is_reg;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  val;
		logic [SAMPLE_BITS-1:0] re;
		logic [SAMPLE_BITS-1:0] im;
		logic                   typed;
		csum_t                  want;
	} plan_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic [USER_W-1:0]      m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// shadow geometry and running-sum state
	logic [SIZE_BITS-1:0] dim_size [NUM_DIMS];
	logic                 col_major_q;
	logic [1:0]           sum_dim_q;
	logic                 cplx_q;
	longint               run_re [STRIDE_DEPTH];
	longint               run_im [STRIDE_DEPTH];
	longint unsigned      stride_at;
	longint unsigned      along_at;

	csum_t     sum_q [$];
	plan_row_t plan [$];
	int        fails       = 0;
	int        cycles      = 0;
	bit        took        = 1'b0;
	int        rx_hold     = 0;
	bit        tx_idle_on  = 1'b1;
	bit        rx_idle_on  = 1'b1;

	strided_cumulative_sum_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clip_sum(input longint v, inout logic clip);
		if (v > SUM_HI) begin
			clip = 1'b1;
			return SUM_HI;
		end
		if (v < SUM_LO) begin
			clip = 1'b1;
			return SUM_LO;
		end
		return v;
	endfunction

	function automatic csum_t predict_csum(input logic [SAMPLE_BITS-1:0] re_in,
			input logic [SAMPLE_BITS-1:0] im_in);
		longint unsigned sz [NUM_DIMS];
		longint unsigned k;
		longint unsigned len;
		longint          xr;
		longint          xi;
		longint          yr;
		longint          yi;
		logic            clip;
		int              d;
		csum_t           r;
		k    = 1;
		clip = 1'b0;
		r    = '0;
		for (int i = 0; i < NUM_DIMS; i++)
			sz[i] = (dim_size[i] == 0) ? 1 : dim_size[i];
		d   = int'(sum_dim_q & LAST_DIM);
		len = sz[d];
		if (col_major_q) begin
			for (int i = 0; i < d; i++)
				k *= sz[i];
		end else begin
			for (int i = d + 1; i < NUM_DIMS; i++)
				k *= sz[i];
		end
		xr = longint'(signed'(re_in));
		xi = cplx_q ? longint'(signed'(im_in)) : 64'sd0;
		if (k > STRIDE_DEPTH) begin
			r.re  = xr[SUM_BITS-1:0];
			r.im  = xi[SUM_BITS-1:0];
			r.err = 1'b1;
			return r;
		end
		if (along_at == 0) begin
			yr = clip_sum(xr, clip);
			yi = clip_sum(xi, clip);
		end else begin
			yr = clip_sum(run_re[stride_at] + xr, clip);
			yi = clip_sum(run_im[stride_at] + xi, clip);
		end
		run_re[stride_at] = yr;
		run_im[stride_at] = yi;
		r.re   = yr[SUM_BITS-1:0];
		r.im   = yi[SUM_BITS-1:0];
		r.sat  = clip;
		r.last = (along_at + 1 >= len);
		if (stride_at + 1 >= k) begin
			stride_at = 0;
			along_at  = (along_at + 1 >= len) ? 0 : along_at + 1;
		end else begin
			stride_at++;
		end
		return r;
	endfunction

	function automatic void note_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		logic hit;
		hit = 1'b1;
		case (idx)
			REG_SIZE_ROWS:    dim_size[0] = val;
			REG_SIZE_COLS:    dim_size[1] = val;
			REG_SIZE_SLICES:  dim_size[2] = val;
			REG_SIZE_HYPER:   dim_size[3] = val;
			REG_COL_MAJOR:    col_major_q = val[0];
			REG_SUM_DIM:      sum_dim_q   = val[1:0] & LAST_DIM;
			REG_COMPLEX_MODE: cplx_q      = val[0];
			default:          hit         = 1'b0;
		endcase
		if (hit) begin
			stride_at = 0;
			along_at  = 0;
		end
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return $urandom_range(0, 15) - 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row        = '0;
		row.is_reg = 1'b1;
		row.idx    = idx;
		row.val    = val;
		plan.push_back(row);
	endtask

	task automatic plan_item(input logic [SAMPLE_BITS-1:0] re, input logic [SAMPLE_BITS-1:0] im);
		plan_row_t row;
		row    = '0;
		row.re = re;
		row.im = im;
		plan.push_back(row);
	endtask

	task automatic plan_check(input logic [SAMPLE_BITS-1:0] re, input logic [SAMPLE_BITS-1:0] im,
			input logic [SUM_BITS-1:0] ere, input logic [SUM_BITS-1:0] eim,
			input logic last, input logic err);
		plan_row_t row;
		row           = '0;
		row.re        = re;
		row.im        = im;
		row.typed     = 1'b1;
		row.want.re   = ere;
		row.want.im   = eim;
		row.want.last = last;
		row.want.err  = err;
		plan.push_back(row);
	endtask

	// entered and left at a falling edge
	task automatic drive_item(input logic [SAMPLE_BITS-1:0] re, input logic [SAMPLE_BITS-1:0] im,
			input logic typed, input csum_t want);
		int    gap;
		csum_t got;
		gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {im, re};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		got = predict_csum(re, im);
		sum_q.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		s_tvalid <= 1'b0;
		while (sum_q.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		note_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [SUM_BITS-1:0] want,
			input logic [SUM_BITS-1:0] got);
		if (got !== want) begin
			$error("%s expected %h, got %h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : check_sums
		csum_t w;
		if (arst_n && m_tvalid && m_tready) begin
			took = 1'b1;
			if (sum_q.size() == 0) begin
				$error("result transfer with nothing expected: sum_re %h",
					m_tdata[SUM_BITS-1:0]);
				fails++;
			end else begin
				w = sum_q.pop_front();
				check_field("sum_re", w.re, m_tdata[SUM_BITS-1:0]);
				check_field("sum_im", w.im, m_tdata[2*SUM_BITS-1:SUM_BITS]);
				check_field("saturated", SUM_BITS'(w.sat), SUM_BITS'(m_tuser[USER_SAT]));
				check_field("vector_end", SUM_BITS'(w.last), SUM_BITS'(m_tlast));
				check_field("stride_error", SUM_BITS'(w.err), SUM_BITS'(m_tuser[USER_ERR]));
			end
		end
	end

	always @(negedge clk) begin
		if (took) begin
			took    = 1'b0;
			rx_hold = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		end
		if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		int                    order [NUM_REGS];
		logic [CFG_DATA_W-1:0] geo [NUM_REGS];
		int                    n_items;
		int                    j;
		int                    tmp;
		for (int i = 0; i < NUM_DIMS; i++)
			dim_size[i] = SIZE_BITS'(1);
		col_major_q = 1'b1;
		sum_dim_q   = 2'd0;
		cplx_q      = 1'b0;
		stride_at   = 0;
		along_at    = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// after reset: stride 1, length 1, real mode, every sample passes through
		plan_check(S_MAX, 32'h1234_5678, W_MAX, '0, 1'b1, 1'b0);
		plan_check(S_MIN, '1, W_MIN, '0, 1'b1, 1'b0);
		plan_check('1, S_MIN, '1, '0, 1'b1, 1'b0);
		plan_check('0, S_MAX, '0, '0, 1'b1, 1'b0);
		plan_reg(REG_COMPLEX_MODE, 16'd1);
		plan_check(S_MIN, S_MAX, W_MIN, W_MAX, 1'b1, 1'b0);
		plan_check(S_MAX, S_MIN, W_MAX, W_MIN, 1'b1, 1'b0);
		// zero size acts as one
		plan_reg(REG_SIZE_ROWS, 16'd0);
		plan_check(32'd1, '1, 48'd1, '1, 1'b1, 1'b0);
		// row-major, stride 2, length 3
		plan_reg(REG_COL_MAJOR, 16'd0);
		plan_reg(REG_SUM_DIM, 16'd0);
		plan_reg(REG_SIZE_ROWS, 16'd3);
		plan_reg(REG_SIZE_COLS, 16'd2);
		plan_item(S_MAX, S_MIN);
		plan_item(S_MAX, S_MIN);
		plan_item(S_MAX, S_MIN);
		plan_item(S_MIN, S_MAX);
		plan_item(32'd5, 32'hFFFF_FFFD);
		plan_item(S_MAX, 32'd1);
		// over-long strides pass the sample through
		plan_reg(REG_SIZE_COLS, 16'hFFFF);
		plan_check(S_MIN, 32'd1, W_MIN, 48'd1, 1'b0, 1'b1);
		plan_reg(REG_SIZE_COLS, 16'd4097);
		plan_check(32'd5, 32'hFFFF_FFFB, 48'd5, 48'hFFFF_FFFF_FFFB, 1'b0, 1'b1);
		plan_reg(REG_SIZE_COLS, 16'd4096);
		plan_check(S_MAX, S_MIN, W_MAX, W_MIN, 1'b0, 1'b0);
		plan_item(S_MIN, S_MIN);
		// indexes past the register list leave the counters alone
		plan_reg(REG_PAST_END, 16'hFFFF);
		plan_reg(REG_TOP, 16'h0000);
		plan_item(S_MAX, S_MAX);
		plan_reg(REG_COMPLEX_MODE, 16'd0);
		plan_reg(REG_SIZE_COLS, 16'd1);
		plan_item(S_MAX, S_MAX);
		plan_item(S_MAX, S_MIN);
		plan_item(S_MIN, 32'd1);
		plan_item(32'd7, S_MAX);
		plan_reg(REG_SUM_DIM, 16'd3);
		plan_reg(REG_COL_MAJOR, 16'd1);
		plan_reg(REG_SIZE_HYPER, 16'd2);
		plan_item(32'd1, 32'd2);
		plan_item(S_MIN, 32'd3);
		plan_item(32'd9, 32'd4);

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				drive_reg(plan[i].idx, plan[i].val);
			else
				drive_item(plan[i].re, plan[i].im, plan[i].typed, plan[i].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			for (int r = 0; r < NUM_DIMS; r++)
				geo[r] = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
			geo[REG_COL_MAJOR]    = 16'($urandom_range(0, 1));
			geo[REG_SUM_DIM]      = 16'($urandom_range(0, 3));
			geo[REG_COMPLEX_MODE] = 16'($urandom_range(0, 1));
			n_items = $urandom_range(30, 60);
			case (p)
				0: begin
					// full-depth stride, first pass only
					geo[REG_SIZE_ROWS]   = 16'd2;
					geo[REG_SIZE_COLS]   = 16'd64;
					geo[REG_SIZE_SLICES] = 16'd64;
					geo[REG_SIZE_HYPER]  = 16'd1;
					geo[REG_COL_MAJOR]   = 16'd0;
					geo[REG_SUM_DIM]     = 16'd0;
					n_items = 24;
				end
				1: begin
					geo[REG_SIZE_ROWS] = 16'hFFFF;
					geo[REG_COL_MAJOR] = 16'd1;
					geo[REG_SUM_DIM]   = 16'd0;
					n_items = 40;
				end
				2: begin
					for (int r = 0; r < NUM_DIMS; r++)
						geo[r] = 16'hFFFF;
					geo[REG_COL_MAJOR] = 16'd1;
					geo[REG_SUM_DIM]   = 16'd3;
					n_items = 16;
				end
				3: begin
					for (int r = 0; r < NUM_DIMS; r++)
						geo[r] = 16'd0;
					n_items = 20;
				end
				4: begin
					geo[REG_SIZE_ROWS]   = 16'd3;
					geo[REG_SIZE_COLS]   = 16'd8;
					geo[REG_SIZE_SLICES] = 16'd12;
					geo[REG_SIZE_HYPER]  = 16'd1;
					geo[REG_COL_MAJOR]   = 16'd0;
					geo[REG_SUM_DIM]     = 16'd0;
					n_items = 232;
				end
				default: ;
			endcase
			// junk in the unused upper bits of the one- and two-bit registers
			geo[REG_COL_MAJOR]    = geo[REG_COL_MAJOR] | (16'($urandom) & 16'hFFFE);
			geo[REG_SUM_DIM]      = geo[REG_SUM_DIM] | (16'($urandom) & 16'hFFFC);
			geo[REG_COMPLEX_MODE] = geo[REG_COMPLEX_MODE] | (16'($urandom) & 16'hFFFE);
			for (int r = 0; r < NUM_REGS; r++)
				order[r] = r;
			for (int r = NUM_REGS - 1; r > 0; r--) begin
				j        = $urandom_range(0, r);
				tmp      = order[r];
				order[r] = order[j];
				order[j] = tmp;
			end
			for (int r = 0; r < NUM_REGS; r++)
				drive_reg(CFG_IDX_W'(order[r]), geo[order[r]]);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < n_items; i++) begin
				if (p % 3 == 0 && i == n_items / 2) begin
					// hold off until the pipeline has drained
					s_tvalid <= 1'b0;
					do @(negedge clk); while (sum_q.size() != 0);
				end
				drive_item(rand_sample(), rand_sample(), 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (sum_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
